>>> hw/rtl/fvws_pkg.sv
// fvws_pkg: shared codes, widths and types of the four-voice wavetable synth.
// No dependencies; every other file of the block imports it.
package fvws_pkg;

  // Input item kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_TABLE_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PHASE_WRITE = 2'd2;

  // Input payload widths
  localparam int ADDR_W     = 11;
  localparam int BYTE_W     = 8;
  localparam int VSEL_W     = 2;
  localparam int PHASE_IN_W = 24;

  // Configuration port and register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] CFG_RUN_MASK      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_VOLUME = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_ZERO     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_ONE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TWO      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_THREE    = 3'd5;

  localparam int RUN_MASK_W     = 4;
  localparam int VOLUME_W       = 8;
  localparam int STEP_W         = 24;
  localparam int STEP_REG_COUNT = 4;

  // Mixing: voice sum covers up to eight voices of -128..127
  localparam int SUM_W      = 11;
  localparam int MIX_SHIFT  = 11;
  localparam int SAMPLE_W   = 7;
  localparam int SAMPLE_MIN = -64;
  localparam int SAMPLE_MAX = 63;

  // Result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Voice pipeline to mixer: tick acceptance and finished voice sums
  typedef struct packed {
    logic tick_taken;
    logic sum_valid;
    sum_t sum;
  } seq_evt_t;

endpackage

>>> hw/rtl/fvws_in_if.sv
// fvws_in_if: input channel of the synth, valid/ready plus one input item.
// Depends on fvws_pkg.
interface fvws_in_if;
  import fvws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [ADDR_W-1:0]     table_address;
  logic [BYTE_W-1:0]     table_byte;
  logic [VSEL_W-1:0]     voice_select;
  logic [PHASE_IN_W-1:0] phase_value;

  modport source (output valid, kind, table_address, table_byte, voice_select,
                  phase_value, input ready);
  modport sink   (input valid, kind, table_address, table_byte, voice_select,
                  phase_value, output ready);
endinterface

>>> hw/rtl/fvws_out_if.sv
// fvws_out_if: result channel of the synth, valid/ready plus one mixed sample.
// Depends on fvws_pkg.
interface fvws_out_if;
  import fvws_pkg::*;

  logic    valid;
  logic    ready;
  sample_t mixed_sample;

  modport source (output valid, mixed_sample, input ready);
  modport sink   (input valid, mixed_sample, output ready);
endinterface

>>> hw/rtl/fvws_voice_pipe.sv
// fvws_voice_pipe: issue sequencer, phase memory, wave memory and voice sum.
// Depends on fvws_pkg and fvws_in_if.
module fvws_voice_pipe #(
  parameter int TABLE_BYTES = 512,
  parameter int PHASE_BITS  = 24,
  parameter int VOICE_COUNT = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  fvws_in_if.sink                                in_chan,
  input  logic                                   room,
  input  logic [VOICE_COUNT-1:0]                 run_vec,
  input  logic [VOICE_COUNT-1:0][fvws_pkg::STEP_W-1:0] step_vec,
  output fvws_pkg::seq_evt_t                     evt
);
  import fvws_pkg::*;

  localparam int WAVE_BYTES = TABLE_BYTES * VOICE_COUNT;
  localparam int WAW        = $clog2(WAVE_BYTES);
  localparam int IB         = $clog2(TABLE_BYTES);
  localparam int VW         = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SW         = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
  localparam int LAST_VOICE = VOICE_COUNT - 1;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef enum logic [1:0] {OP_NONE, OP_TABLE, OP_TICK, OP_PHASE} op_t;

  // Clearing pass and tick sequencing
  logic           clearing_r;
  logic [WAW-1:0] clr_cnt_r;
  logic           busy_r;
  logic [VW-1:0]  voice_r;

  // Stage B (read data back, modify, write)
  op_t             b_op_r;
  logic [VW-1:0]   b_voice_r;
  logic [WAW-1:0]  b_waddr_r;
  logic [BYTE_W-1:0] b_byte_r;
  phase_t          b_phase_r;
  logic            b_fwd_r;
  phase_t          b_fwd_data_r;

  // Stage C (wave byte back, accumulate)
  logic            c_tick_r;
  logic            c_first_r;
  logic            c_last_r;
  sum_t            acc_r;

  // Memories
  phase_t          phase_mem [VOICE_COUNT];
  phase_t          ph_rd_r;
  logic [BYTE_W-1:0] wave_mem [WAVE_BYTES];
  logic [BYTE_W-1:0] wave_rd_r;

  logic            in_fire;
  op_t             iss_op;
  logic [VW-1:0]   iss_voice;
  logic            b_ph_write;
  phase_t          phase_cur;
  phase_t          phase_adv;
  phase_t          phase_wdata;
  logic            ph_we;
  logic [VW-1:0]   ph_waddr;
  phase_t          ph_wdata;
  logic            wave_we;
  logic [WAW-1:0]  wave_addr;
  logic [BYTE_W-1:0] wave_wdata;
  logic [WAW-1:0]  wave_raddr;
  logic signed [BYTE_W-1:0] sample;
  sum_t            acc_sum;

  assign in_chan.ready = !clearing_r && !busy_r && room;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Issue: the continuing tick owns the slot, otherwise the accepted item
  always_comb begin
    iss_op    = OP_NONE;
    iss_voice = '0;
    if (busy_r) begin
      iss_op    = OP_TICK;
      iss_voice = voice_r;
    end else if (in_fire) begin
      unique case (in_chan.kind)
        KIND_TABLE_WRITE: begin
          if (int'(in_chan.table_address) < WAVE_BYTES) iss_op = OP_TABLE;
        end
        KIND_TICK: iss_op = OP_TICK;
        KIND_PHASE_WRITE: begin
          iss_voice = VW'(in_chan.voice_select);
          if (int'(in_chan.voice_select) < VOICE_COUNT) iss_op = OP_PHASE;
        end
        default: iss_op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      busy_r     <= 1'b0;
      voice_r    <= '0;
      b_op_r     <= OP_NONE;
      b_fwd_r    <= 1'b0;
      c_tick_r   <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + WAW'(1);
        if (clr_cnt_r == WAW'(WAVE_BYTES - 1)) clearing_r <= 1'b0;
      end
      if (busy_r) begin
        if (voice_r == VW'(LAST_VOICE)) begin
          busy_r <= 1'b0;
        end else begin
          voice_r <= voice_r + VW'(1);
        end
      end else if ((VOICE_COUNT > 1) && in_fire && (in_chan.kind == KIND_TICK)) begin
        busy_r  <= 1'b1;
        voice_r <= VW'(1);
      end
      b_op_r   <= iss_op;
      // forward the entry that stage B writes while this slot reads it
      b_fwd_r  <= b_ph_write && (b_voice_r == iss_voice);
      c_tick_r <= (b_op_r == OP_TICK);
    end
  end

  // Payload of the stages, no reset needed
  always_ff @(posedge clk) begin
    b_voice_r    <= iss_voice;
    b_waddr_r    <= WAW'(in_chan.table_address);
    b_byte_r     <= in_chan.table_byte;
    b_phase_r    <= PHASE_BITS'(SW'(in_chan.phase_value));
    b_fwd_data_r <= phase_wdata;
    c_first_r    <= (b_voice_r == '0);
    c_last_r     <= (b_voice_r == VW'(LAST_VOICE));
    if (c_tick_r) acc_r <= acc_sum;
  end

  // Stage B: advance or set the phase, write it back, address or write the wave byte
  assign b_ph_write  = (b_op_r == OP_TICK) || (b_op_r == OP_PHASE);
  assign phase_cur   = b_fwd_r ? b_fwd_data_r : ph_rd_r;
  assign phase_adv   = PHASE_BITS'(SW'(phase_cur) +
                                   (run_vec[b_voice_r] ? SW'(step_vec[b_voice_r]) : SW'(0)));
  assign phase_wdata = (b_op_r == OP_PHASE) ? b_phase_r : phase_adv;
  assign wave_raddr  = WAW'({b_voice_r, phase_adv[PHASE_BITS-1 -: IB]});

  always_comb begin
    if (clearing_r) begin
      ph_we      = (int'(clr_cnt_r) < VOICE_COUNT);
      ph_waddr   = VW'(clr_cnt_r);
      ph_wdata   = '0;
      wave_we    = 1'b1;
      wave_addr  = clr_cnt_r;
      wave_wdata = '0;
    end else begin
      ph_we      = b_ph_write;
      ph_waddr   = b_voice_r;
      ph_wdata   = phase_wdata;
      wave_we    = (b_op_r == OP_TABLE);
      wave_addr  = (b_op_r == OP_TABLE) ? b_waddr_r : wave_raddr;
      wave_wdata = b_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ph_we) phase_mem[ph_waddr] <= ph_wdata;
    ph_rd_r <= phase_mem[iss_voice];
  end

  always_ff @(posedge clk) begin
    if (wave_we) wave_mem[wave_addr] <= wave_wdata;
    wave_rd_r <= wave_mem[wave_addr];
  end

  // Stage C: offset binary to signed, sum the voices of one tick
  assign sample  = $signed({~wave_rd_r[BYTE_W-1], wave_rd_r[BYTE_W-2:0]});
  assign acc_sum = c_first_r ? SUM_W'(sample) : acc_r + SUM_W'(sample);

  assign evt.tick_taken = in_fire && (in_chan.kind == KIND_TICK);
  assign evt.sum_valid  = c_tick_r && c_last_r;
  assign evt.sum        = acc_sum;

endmodule

>>> hw/rtl/fvws_mix.sv
// fvws_mix: volume multiply, divide by 2048 toward zero, clamp, result queue.
// Depends on fvws_pkg and fvws_out_if.
module fvws_mix (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fvws_pkg::seq_evt_t            evt,
  input  logic [fvws_pkg::VOLUME_W-1:0] volume,
  output logic                          room,
  fvws_out_if.source                    out_chan
);
  import fvws_pkg::*;

  localparam int PROD_W = SUM_W + VOLUME_W + 1;
  localparam logic signed [PROD_W-1:0] BIAS   = PROD_W'((1 << MIX_SHIFT) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(SAMPLE_MIN);
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(SAMPLE_MAX);

  logic                     d_valid_r;
  sum_t                     d_sum_r;
  logic                     e_valid_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] quo;
  sample_t                  res;

  sample_t                  fifo_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]     wr_ptr_r;
  logic [OUT_PTR_W-1:0]     rd_ptr_r;
  logic [OUT_CNT_W-1:0]     cnt_r;
  logic [OUT_CNT_W-1:0]     pend_r;
  logic                     push;
  logic                     pop;

  assign biased = prod_r + (prod_r[PROD_W-1] ? BIAS : PROD_W'(0));
  assign quo    = biased >>> MIX_SHIFT;

  always_comb begin
    if (quo < SAT_LO) begin
      res = SAMPLE_W'(SAT_LO);
    end else if (quo > SAT_HI) begin
      res = SAMPLE_W'(SAT_HI);
    end else begin
      res = SAMPLE_W'(quo);
    end
  end

  assign push              = e_valid_r;
  assign pop               = out_chan.valid && out_chan.ready;
  assign out_chan.valid        = (cnt_r != '0);
  assign out_chan.mixed_sample = fifo_mem[rd_ptr_r];
  // ticks accepted but not yet delivered never outgrow the queue
  assign room              = (int'(pend_r) < OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      pend_r    <= '0;
    end else begin
      d_valid_r <= evt.sum_valid;
      e_valid_r <= d_valid_r;
      if (push) wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + OUT_CNT_W'(1);
      end else if (!push && pop) begin
        cnt_r <= cnt_r - OUT_CNT_W'(1);
      end
      if (evt.tick_taken && !pop) begin
        pend_r <= pend_r + OUT_CNT_W'(1);
      end else if (!evt.tick_taken && pop) begin
        pend_r <= pend_r - OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    d_sum_r <= evt.sum;
    prod_r  <= PROD_W'(d_sum_r) * PROD_W'($signed({1'b0, volume}));
    if (push) fifo_mem[wr_ptr_r] <= res;
  end

endmodule

>>> hw/rtl/four_voice_wavetable_synth.sv
// Four-voice wavetable synth top level: configuration registers, voice pipeline, mixer.
// Tick: voices issue in turn (one wave memory read and one phase read each); no new item
// is taken until the last voice issues. Table and phase writes: one item per cycle unless
// input is held off. Results pass stages B and C and the mixer into a queue OUT_DEPTH deep.
// Reset (rst_n low, synchronous): registers clear, input is held off, and a clearing pass
// over VOICE_COUNT * TABLE_BYTES (2048 by default) wave bytes, zeroing them and the phases.
module four_voice_wavetable_synth #(
  parameter int TABLE_BYTES = 512,
  parameter int PHASE_BITS  = 24,
  parameter int VOICE_COUNT = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fvws_in_if.sink                          in_chan,
  fvws_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [fvws_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fvws_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fvws_pkg::*;

  // Voices beyond the step registers never run and have step zero
  localparam int STEP_REGS = (VOICE_COUNT < STEP_REG_COUNT) ? VOICE_COUNT : STEP_REG_COUNT;
  localparam int SRW       = (STEP_REGS > 1) ? $clog2(STEP_REGS) : 1;

  logic [RUN_MASK_W-1:0]          run_mask_r;
  logic [VOLUME_W-1:0]            volume_r;
  logic [STEP_W-1:0]              step_r [STEP_REGS];
  logic [CFG_INDEX_W-1:0]         step_slot;
  logic [VOICE_COUNT-1:0]         run_vec;
  logic [VOICE_COUNT-1:0][STEP_W-1:0] step_vec;
  seq_evt_t                       evt;
  logic                           room;

  // Configuration writes: decode the index, mask data to the register width
  assign step_slot = cfg_index - CFG_STEP_ZERO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mask_r <= '0;
      volume_r   <= '0;
      for (int v = 0; v < STEP_REGS; v++) step_r[v] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_RUN_MASK:      run_mask_r <= cfg_wdata[RUN_MASK_W-1:0];
        CFG_MASTER_VOLUME: volume_r   <= cfg_wdata[VOLUME_W-1:0];
        CFG_STEP_ZERO, CFG_STEP_ONE, CFG_STEP_TWO, CFG_STEP_THREE: begin
          // drop a step write aimed at a voice that does not exist
          if (int'(step_slot) < STEP_REGS) step_r[step_slot[SRW-1:0]] <= cfg_wdata[STEP_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Per-voice run enable and step, zero for voices without registers
  for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_voice
    if (v < STEP_REGS) begin : g_reg
      assign run_vec[v]  = run_mask_r[v];
      assign step_vec[v] = step_r[v];
    end else begin : g_none
      assign run_vec[v]  = 1'b0;
      assign step_vec[v] = '0;
    end
  end

  // Phase read-modify-write and wave reads, one voice per cycle
  fvws_voice_pipe #(
    .TABLE_BYTES (TABLE_BYTES),
    .PHASE_BITS  (PHASE_BITS),
    .VOICE_COUNT (VOICE_COUNT)
  ) u_voice_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .room     (room),
    .run_vec  (run_vec),
    .step_vec (step_vec),
    .evt      (evt)
  );

  // Gain, scale, clamp, and hold results until the consumer takes the beat
  fvws_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt      (evt),
    .volume   (volume_r),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

>>> hw/rtl/fvws_checker.sv
// fvws_checker: port-level checks of the synth top level, attached by bind.
// Depends on fvws_pkg and four_voice_wavetable_synth.
module fvws_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [fvws_pkg::KIND_W-1:0]   in_kind,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fvws_pkg::SAMPLE_W-1:0] out_sample
);
  import fvws_pkg::*;

  // Ticks accepted whose result beat has not gone out yet
  logic [OUT_CNT_W:0] outstanding_r;
  logic               tick_beat;
  logic               out_beat;

  assign tick_beat = in_valid && in_ready && (in_kind == KIND_TICK);
  assign out_beat  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else if (tick_beat && !out_beat) begin
      outstanding_r <= outstanding_r + (OUT_CNT_W + 1)'(1);
    end else if (!tick_beat && out_beat) begin
      outstanding_r <= outstanding_r - (OUT_CNT_W + 1)'(1);
    end
  end

  a_reset_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in_held: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during wave memory clearing");

  a_result_has_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> (outstanding_r != '0))
    else $error("result beat without an accepted tick");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tick_beat |-> (int'(outstanding_r) < OUT_DEPTH))
    else $error("tick accepted with the result queue committed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled result beat changed");

endmodule

bind four_voice_wavetable_synth fvws_checker u_fvws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_kind    (in_chan.kind),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_sample (out_chan.mixed_sample)
);
